FILE: src/lrc_rx_pkg.sv
// Shared types and constants for the framed LRC byte receiver.
`timescale 1ns / 1ps

package lrc_rx_pkg;

   localparam int unsigned ByteWidth       = 8;
   localparam int unsigned TickWidth       = 16;
   localparam int unsigned CountWidth      = 15;
   localparam int unsigned CsrAddrWidth    = 2;
   localparam int unsigned CsrDataWidth    = 16;
   localparam int unsigned RspDataWidth    = 16;

   localparam logic [CountWidth-1:0] MaxPayload     = 15'd16384;
   localparam logic [TickWidth-1:0]  DefaultTimeout = 16'd20;

   localparam logic [ByteWidth-1:0]  StartCodeReset = 8'd2;
   localparam logic [ByteWidth-1:0]  EndCodeReset   = 8'd3;
   localparam logic [TickWidth-1:0]  TimeoutReset   = 16'd20;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_START_CODE    = 2'd0,
      CSR_END_CODE      = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_LRC  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_LRC_ERR  = 2'd1,
      ST_TIMEOUT  = 2'd2,
      ST_OVERFLOW = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic                 is_frame_end;
      logic [ByteWidth-1:0] payload_byte;
      frame_status_type     frame_status;
   } result_type;

endpackage

FILE: src/stx_etx_lrc_frame_receiver_unit.sv
// Framed serial byte receiver: start/end code framing, XOR LRC check, timeout and overflow.
`timescale 1ns / 1ps

// A result goes to the result register, which drives the rsp_ side, or to the skid register
// while the port is stalled; the byte or tick is decoded and the frame state updated as the
// req_ transaction is accepted. Throughput: one transaction per cycle while the skid register
// is empty; this two-entry buffer lets req_tready stay high while one result waits downstream.
// Reset (synchronous, active high) returns to hunting for the start code, clears the LRC
// and counters, empties the output buffer and restores start 2, end 3, timeout 20 ticks.
module stx_etx_lrc_frame_receiver_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port.
   input  logic                                  csr_we,
   input  logic [lrc_rx_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [lrc_rx_pkg::CsrDataWidth-1:0]   csr_wdata,
   // Input stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lrc_rx_pkg::ByteWidth-1:0]      req_tdata,   // [7:0] rx_byte
   input  logic                                  req_tuser,   // [0] cmd (1 = timer tick)
   // Result stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lrc_rx_pkg::RspDataWidth-1:0]   rsp_tdata,   // [7:0] payload_byte,
                                                              // [9:8] frame_status, rest 0
   output logic                                  rsp_tlast    // is_frame_end
);

   // Configuration registers.
   logic [lrc_rx_pkg::ByteWidth-1:0]  start_code_ff, start_code_in;
   logic [lrc_rx_pkg::ByteWidth-1:0]  end_code_ff, end_code_in;
   logic [lrc_rx_pkg::TickWidth-1:0]  timeout_ff, timeout_in;

   // Frame state.
   lrc_rx_pkg::phase_type              phase_ff, phase_in;
   logic [lrc_rx_pkg::ByteWidth-1:0]   lrc_ff, lrc_in;
   logic [lrc_rx_pkg::CountWidth-1:0]  pcount_ff, pcount_in;
   logic [lrc_rx_pkg::TickWidth-1:0]   tick_ff, tick_in;

   // Output buffer: the result register drives the port, the skid register catches
   // a result produced while the port is stalled.
   logic                    out_valid_ff, out_valid_in;
   lrc_rx_pkg::result_type  out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   lrc_rx_pkg::result_type  skid_ff, skid_in;

   // Decode of the accepted transaction.
   logic                               accept_in;
   logic                               is_tick;
   logic [lrc_rx_pkg::TickWidth-1:0]   limit;
   logic [lrc_rx_pkg::TickWidth:0]     tick_next;
   logic                               hit_timeout;
   logic                               hit_end;
   logic                               hit_start;
   logic                               hit_overflow;
   logic                               res_valid;
   lrc_rx_pkg::result_type             res;

   assign req_tready = !skid_valid_ff;
   assign accept_in  = req_tvalid && req_tready;
   assign is_tick    = req_tuser;

   // A zero timeout register falls back to the default limit.
   assign limit       = (timeout_ff == '0) ? lrc_rx_pkg::DefaultTimeout : timeout_ff;
   assign tick_next   = {1'b0, tick_ff} + {{lrc_rx_pkg::TickWidth{1'b0}}, 1'b1};
   assign hit_timeout = is_tick && (tick_next > {1'b0, limit});
   assign hit_end     = !is_tick && (req_tdata == end_code_ff);
   assign hit_start   = !is_tick && (req_tdata == start_code_ff);
   assign hit_overflow = !is_tick && !hit_end && (pcount_ff >= lrc_rx_pkg::MaxPayload);

   // Configuration writes take effect on the next edge; unknown indexes are dropped.
   always_comb begin
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      timeout_in    = timeout_ff;
      if (csr_we) begin
         case (csr_addr)
            lrc_rx_pkg::CSR_START_CODE:    start_code_in = csr_wdata[lrc_rx_pkg::ByteWidth-1:0];
            lrc_rx_pkg::CSR_END_CODE:      end_code_in   = csr_wdata[lrc_rx_pkg::ByteWidth-1:0];
            lrc_rx_pkg::CSR_TIMEOUT_TICKS: timeout_in    = csr_wdata[lrc_rx_pkg::TickWidth-1:0];
            default: ;
         endcase
      end
   end

   // Next phase. A frame ends (back to hunting) on timeout, overflow or the check byte.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         lrc_rx_pkg::PH_DATA: begin
            if (accept_in) begin
               if (hit_timeout || hit_overflow) begin
                  phase_in = lrc_rx_pkg::PH_HUNT;
               end else if (hit_end) begin
                  phase_in = lrc_rx_pkg::PH_LRC;
               end
            end
         end
         lrc_rx_pkg::PH_LRC: begin
            if (accept_in && (hit_timeout || !is_tick)) begin
               phase_in = lrc_rx_pkg::PH_HUNT;
            end
         end
         default: begin
            phase_in = (accept_in && hit_start) ? lrc_rx_pkg::PH_DATA : lrc_rx_pkg::PH_HUNT;
         end
      endcase
   end

   // Datapath and result for the accepted transaction.
   always_comb begin
      lrc_in           = lrc_ff;
      pcount_in        = pcount_ff;
      tick_in          = tick_ff;
      res_valid        = 1'b0;
      res.is_frame_end = 1'b0;
      res.payload_byte = '0;
      res.frame_status = lrc_rx_pkg::ST_OK;
      if (accept_in) begin
         case (phase_ff)
            lrc_rx_pkg::PH_DATA, lrc_rx_pkg::PH_LRC: begin
               if (is_tick) begin
                  if (hit_timeout) begin
                     res_valid        = 1'b1;
                     res.is_frame_end = 1'b1;
                     res.frame_status = lrc_rx_pkg::ST_TIMEOUT;
                  end else begin
                     tick_in = tick_next[lrc_rx_pkg::TickWidth-1:0];
                  end
               end else if (phase_ff == lrc_rx_pkg::PH_LRC) begin
                  // Check byte: compare against the running LRC.
                  res_valid        = 1'b1;
                  res.is_frame_end = 1'b1;
                  res.frame_status = (req_tdata == lrc_ff) ? lrc_rx_pkg::ST_OK
                                                           : lrc_rx_pkg::ST_LRC_ERR;
               end else if (hit_end) begin
                  lrc_in = lrc_ff ^ req_tdata;
               end else if (hit_overflow) begin
                  res_valid        = 1'b1;
                  res.is_frame_end = 1'b1;
                  res.frame_status = lrc_rx_pkg::ST_OVERFLOW;
               end else begin
                  lrc_in           = lrc_ff ^ req_tdata;
                  pcount_in        = pcount_ff + {{(lrc_rx_pkg::CountWidth-1){1'b0}}, 1'b1};
                  res_valid        = 1'b1;
                  res.payload_byte = req_tdata;
               end
            end
            default: begin
               if (hit_start) begin
                  lrc_in    = '0;
                  pcount_in = '0;
                  tick_in   = '0;
               end
            end
         endcase
      end
   end

   // Output buffer control. New input is only taken while the skid register is empty,
   // so at most one of "drain skid" and "store new result" happens in a cycle.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_in = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= lrc_rx_pkg::StartCodeReset;
         end_code_ff   <= lrc_rx_pkg::EndCodeReset;
         timeout_ff    <= lrc_rx_pkg::TimeoutReset;
         phase_ff      <= lrc_rx_pkg::PH_HUNT;
         lrc_ff        <= '0;
         pcount_ff     <= '0;
         tick_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         start_code_ff <= start_code_in;
         end_code_ff   <= end_code_in;
         timeout_ff    <= timeout_in;
         phase_ff      <= phase_in;
         lrc_ff        <= lrc_in;
         pcount_ff     <= pcount_in;
         tick_ff       <= tick_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.is_frame_end;
   assign rsp_tdata  = {{(lrc_rx_pkg::RspDataWidth - lrc_rx_pkg::ByteWidth - 2){1'b0}},
                        out_ff.frame_status, out_ff.payload_byte};

   // The skid register is only ever filled behind a full result register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the result register is empty");

   // A data byte taken while awaiting the check byte always closes the frame.
   a_check_byte_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept_in && !is_tick && phase_ff == lrc_rx_pkg::PH_LRC)
      |=> (phase_ff == lrc_rx_pkg::PH_HUNT))
      else $error("frame not closed after the check byte");

   // The payload counter never runs past the maximum payload length.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= lrc_rx_pkg::MaxPayload)
      else $error("payload counter exceeds the maximum payload length");

   // A payload byte result carries no frame status.
   a_payload_status_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.is_frame_end) |-> (out_ff.frame_status == lrc_rx_pkg::ST_OK))
      else $error("payload byte result carries a nonzero status");

endmodule
